/* src/rvxu_pkg.sv */
package rvxu_pkg;

    // Default data memory size in bytes (power of two, at least 4)
    localparam int DMEM_BYTES_DEFAULT = 4096;

    // Program counter value after reset
    localparam logic [31:0] RESET_PC = 32'h0000_0000;

    // Major opcodes
    localparam logic [6:0] OPC_LOAD   = 7'h03;
    localparam logic [6:0] OPC_STORE  = 7'h23;
    localparam logic [6:0] OPC_OPIMM  = 7'h13;
    localparam logic [6:0] OPC_OP     = 7'h33;
    localparam logic [6:0] OPC_LUI    = 7'h37;
    localparam logic [6:0] OPC_JAL    = 7'h6F;
    localparam logic [6:0] OPC_JALR   = 7'h67;
    localparam logic [6:0] OPC_BRANCH = 7'h63;

    // funct3: loads and stores
    localparam logic [2:0] F3_LB  = 3'b000;
    localparam logic [2:0] F3_LH  = 3'b001;
    localparam logic [2:0] F3_LW  = 3'b010;
    localparam logic [2:0] F3_LBU = 3'b100;
    localparam logic [2:0] F3_LHU = 3'b101;
    localparam logic [2:0] F3_SB  = 3'b000;
    localparam logic [2:0] F3_SH  = 3'b001;
    localparam logic [2:0] F3_SW  = 3'b010;

    // funct3: ALU, jumps
    localparam logic [2:0] F3_ADD  = 3'b000;
    localparam logic [2:0] F3_SLL  = 3'b001;
    localparam logic [2:0] F3_SR   = 3'b101;
    localparam logic [2:0] F3_AND  = 3'b111;
    localparam logic [2:0] F3_JALR = 3'b000;

    // funct3: branches
    localparam logic [2:0] F3_BEQ  = 3'b000;
    localparam logic [2:0] F3_BNE  = 3'b001;
    localparam logic [2:0] F3_BLT  = 3'b100;
    localparam logic [2:0] F3_BGE  = 3'b101;
    localparam logic [2:0] F3_BLTU = 3'b110;
    localparam logic [2:0] F3_BGEU = 3'b111;

    // funct7
    localparam logic [6:0] F7_BASE = 7'b0000000;
    localparam logic [6:0] F7_MUL  = 7'b0000001;
    localparam logic [6:0] F7_ALT  = 7'b0100000;

    // Access size, funct3[1:0]
    localparam logic [1:0] SIZE_BYTE = 2'b00;
    localparam logic [1:0] SIZE_HALF = 2'b01;
    localparam logic [1:0] SIZE_WORD = 2'b10;

    typedef enum logic [1:0] {
        FAULT_NONE     = 2'd0,
        FAULT_MISALIGN = 2'd1,
        FAULT_UNSUP    = 2'd2
    } t_fault;

    // Execute stage result, carried into the writeback stage
    typedef struct packed {
        logic [31:0] npc;
        logic        wr;
        logic [4:0]  rd;
        logic [31:0] val;
        logic        ld;
        logic [2:0]  f3;
        logic        mw;
        logic [31:0] maddr;
        t_fault      fault;
    } t_exec;

    // Data memory access
    typedef struct packed {
        logic        wr_en;
        logic        rd_en;
        logic [1:0]  size;
        logic [31:0] addr;
        logic [31:0] wdata;
    } t_mem_req;

    // Result transaction, last field in the low bits
    typedef struct packed {
        t_fault      fault;
        logic [31:0] mem_addr;
        logic        mem_written;
        logic [31:0] dest_value;
        logic [4:0]  dest_reg;
        logic        reg_written;
        logic [31:0] next_pc;
    } t_result;

    localparam int OUT_TDATA_W = (($bits(t_result) + 7) / 8) * 8;

endpackage

/* src/rv32_subset_execute_unit.sv */
// Channel   | Direction | Beat contents
// ----------+-----------+--------------------------------------------------------
// s_axis    | in        | instruction word
// m_axis    | out       | next_pc, reg_written, dest_reg, dest_value, mem_written,
//           |           | mem_addr, fault
// cfg       | in        | program counter write; loads the program counter directly
//
// One instruction per cycle sustained while m_axis is ready and no sweep runs.
// Three-stage pipe: operand read at accept, execute (decode, ALU, 32x32 multiply,
// memory access), writeback into the result register; an accepted instruction
// passes through the execute register, the writeback register and the result register.
// Results feed later instructions through forwarding, so no bubbles are inserted.
// After reset the data memory is swept to zero row by row, with s_axis tready low.
// A stalled m_axis holds the pipe; s_axis keeps accepting until the free stages are full.
module rv32_subset_execute_unit
    import rvxu_pkg::*;
#(
    parameter int DATA_MEM_BYTES = DMEM_BYTES_DEFAULT  // power of two, at least 4
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  logic [31:0]            i_s_axis_tdata,   // [31:0] instruction
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,   // [31:0] next_pc, [32] reg_written,
                                                     // [37:33] dest_reg, [69:38] dest_value,
                                                     // [70] mem_written, [102:71] mem_addr,
                                                     // [104:103] fault, rest zero
    input  logic                   i_cfg_wr_en,
    input  logic [31:0]            i_cfg_wr_data
);

    // Register file with per-entry valid bits (invalid reads as zero)
    logic [31:0] r_rf [0:31];
    logic [31:0] r_rf_vld;

    // Execute stage
    logic        r_s2_valid;
    logic [31:0] r_s2_ins;
    logic [31:0] r_rf_rd_a;
    logic [31:0] r_rf_rd_b;
    logic        r_ovr_a;
    logic        r_ovr_b;
    logic [31:0] r_ovr_a_val;
    logic [31:0] r_ovr_b_val;
    logic [31:0] r_pc;

    // Writeback stage
    logic        r_s3_valid;
    t_exec       r_s3;

    // Result register
    logic        r_out_valid;
    t_result     r_out;

    logic        in_acc;
    logic        out_free;
    logic        s3_adv;
    logic        s3_free;
    logic        s2_adv;
    logic        s2_free;
    logic        mem_busy;
    logic [4:0]  rs1_in;
    logic [4:0]  rs2_in;
    logic [4:0]  rs1_s2;
    logic [4:0]  rs2_s2;
    logic        wb_en;
    logic [31:0] s3_val;
    logic [31:0] load_val;
    logic [31:0] lane;
    logic [31:0] mem_rdata;
    logic [31:0] op_a;
    logic [31:0] op_b;
    logic        n_ovr_a;
    logic        n_ovr_b;
    logic [31:0] n_ovr_a_val;
    logic [31:0] n_ovr_b_val;
    t_exec       ex;
    t_mem_req    mem_req;
    t_result     n_out;

    // Pipeline flow control
    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign s3_adv          = r_s3_valid && out_free;
    assign s3_free         = !r_s3_valid || out_free;
    assign s2_adv          = r_s2_valid && s3_free;
    assign s2_free         = !r_s2_valid || s3_free;
    assign o_s_axis_tready = s2_free && !mem_busy;
    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_s2_valid <= 1'b1;
            end else if (s2_adv) begin
                r_s2_valid <= 1'b0;
            end
            if (s2_adv) begin
                r_s3_valid <= 1'b1;
            end else if (s3_adv) begin
                r_s3_valid <= 1'b0;
            end
            if (s3_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Writeback from the last stage
    assign wb_en = s3_adv && r_s3.wr;

    // Operand read at accept; a same-edge writeback or an unwritten entry overrides
    assign rs1_in = i_s_axis_tdata[19:15];
    assign rs2_in = i_s_axis_tdata[24:20];

    always_comb begin
        n_ovr_a     = 1'b0;
        n_ovr_a_val = '0;
        if (wb_en && (r_s3.rd == rs1_in)) begin
            n_ovr_a     = 1'b1;
            n_ovr_a_val = s3_val;
        end else if (!r_rf_vld[rs1_in]) begin
            n_ovr_a = 1'b1;
        end
        n_ovr_b     = 1'b0;
        n_ovr_b_val = '0;
        if (wb_en && (r_s3.rd == rs2_in)) begin
            n_ovr_b     = 1'b1;
            n_ovr_b_val = s3_val;
        end else if (!r_rf_vld[rs2_in]) begin
            n_ovr_b = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wb_en) begin
            r_rf[r_s3.rd] <= s3_val;
        end
        if (in_acc) begin
            r_rf_rd_a   <= r_rf[rs1_in];
            r_rf_rd_b   <= r_rf[rs2_in];
            r_ovr_a     <= n_ovr_a;
            r_ovr_b     <= n_ovr_b;
            r_ovr_a_val <= n_ovr_a_val;
            r_ovr_b_val <= n_ovr_b_val;
            r_s2_ins    <= i_s_axis_tdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rf_vld <= '0;
        end else if (wb_en) begin
            r_rf_vld[r_s3.rd] <= 1'b1;
        end
    end

    // Forward from the writeback stage into execute
    assign rs1_s2 = r_s2_ins[19:15];
    assign rs2_s2 = r_s2_ins[24:20];

    always_comb begin
        op_a = r_ovr_a ? r_ovr_a_val : r_rf_rd_a;
        op_b = r_ovr_b ? r_ovr_b_val : r_rf_rd_b;
        if (r_s3_valid && r_s3.wr && (r_s3.rd == rs1_s2)) begin
            op_a = s3_val;
        end
        if (r_s3_valid && r_s3.wr && (r_s3.rd == rs2_s2)) begin
            op_b = s3_val;
        end
    end

    rvxu_exec u_exec (
        .i_ins (r_s2_ins),
        .i_pc  (r_pc),
        .i_a   (op_a),
        .i_b   (op_b),
        .o_res (ex)
    );

    // Program counter; a configuration write loads it directly
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= RESET_PC;
        end else if (i_cfg_wr_en) begin
            r_pc <= i_cfg_wr_data;
        end else if (s2_adv) begin
            r_pc <= ex.npc;
        end
    end

    // Memory access issued as execute hands over
    assign mem_req.wr_en = s2_adv && ex.mw;
    assign mem_req.rd_en = s2_adv && ex.ld;
    assign mem_req.size  = ex.f3[1:0];
    assign mem_req.addr  = ex.maddr;
    assign mem_req.wdata = op_b;

    rvxu_dmem #(
        .DATA_MEM_BYTES (DATA_MEM_BYTES)
    ) u_dmem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mem_req),
        .o_rdata (mem_rdata),
        .o_busy  (mem_busy)
    );

    always_ff @(posedge i_clk) begin
        if (s2_adv) begin
            r_s3 <= ex;
        end
    end

    // Load data: pick the lanes, then extend
    assign lane = mem_rdata >> {r_s3.maddr[1:0], 3'b000};

    always_comb begin
        case (r_s3.f3)
            F3_LB:   load_val = {{24{lane[7]}}, lane[7:0]};
            F3_LH:   load_val = {{16{lane[15]}}, lane[15:0]};
            F3_LBU:  load_val = {24'h000000, lane[7:0]};
            F3_LHU:  load_val = {16'h0000, lane[15:0]};
            default: load_val = lane;
        endcase
    end

    assign s3_val = r_s3.ld ? (r_s3.wr ? load_val : 32'h0) : r_s3.val;

    // Result register
    assign n_out.next_pc     = r_s3.npc;
    assign n_out.reg_written = r_s3.wr;
    assign n_out.dest_reg    = r_s3.rd;
    assign n_out.dest_value  = s3_val;
    assign n_out.mem_written = r_s3.mw;
    assign n_out.mem_addr    = r_s3.maddr;
    assign n_out.fault       = r_s3.fault;

    always_ff @(posedge i_clk) begin
        if (s3_adv) begin
            r_out <= n_out;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = OUT_TDATA_W'(r_out);

endmodule

/* src/rvxu_exec.sv */
// Decode and execute of one instruction, purely combinational
module rvxu_exec
    import rvxu_pkg::*;
(
    input  logic [31:0] i_ins,
    input  logic [31:0] i_pc,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output t_exec       o_res
);

    logic [6:0]  opc;
    logic [4:0]  rd;
    logic [2:0]  f3;
    logic [6:0]  f7;
    logic [4:0]  shamt;
    logic [31:0] immi;
    logic [31:0] imms;
    logic [31:0] immb;
    logic [31:0] immj;
    logic [31:0] pc4;
    logic [31:0] ea;
    logic [31:0] pc_tgt;
    logic [31:0] mul_lo;
    logic [31:0] sra_val;
    logic        lt_s;
    logic        lt_u;
    logic        eq;
    logic        misal;

    logic        wr;
    logic        mw;
    logic        ld;
    logic        take;
    logic [31:0] val;
    logic [31:0] npc;
    logic [31:0] maddr;
    t_fault      fault;

    // Field split and immediates
    assign opc   = i_ins[6:0];
    assign rd    = i_ins[11:7];
    assign f3    = i_ins[14:12];
    assign f7    = i_ins[31:25];
    assign shamt = i_ins[24:20];
    assign immi  = {{20{i_ins[31]}}, i_ins[31:20]};
    assign imms  = {{20{i_ins[31]}}, i_ins[31:25], i_ins[11:7]};
    assign immb  = {{20{i_ins[31]}}, i_ins[7], i_ins[30:25], i_ins[11:8], 1'b0};
    assign immj  = {{12{i_ins[31]}}, i_ins[19:12], i_ins[20], i_ins[30:21], 1'b0};

    // Shared adders: rs1 + imm serves addresses, ADDI and JALR
    assign pc4    = i_pc + 32'd4;
    assign ea     = i_a + ((opc == OPC_STORE) ? imms : immi);
    assign pc_tgt = i_pc + ((opc == OPC_JAL) ? immj : immb);

    assign mul_lo  = i_a * i_b;
    assign sra_val = $unsigned($signed(i_a) >>> shamt);
    assign lt_s    = $signed(i_a) < $signed(i_b);
    assign lt_u    = i_a < i_b;
    assign eq      = i_a == i_b;

    // Word needs two low zero bits, half one; bytes always fit
    assign misal = ((f3[1:0] == SIZE_WORD) && (ea[1:0] != 2'b00)) ||
                   ((f3[1:0] == SIZE_HALF) && ea[0]);

    always_comb begin
        wr    = 1'b0;
        mw    = 1'b0;
        ld    = 1'b0;
        take  = 1'b0;
        val   = '0;
        npc   = pc4;
        maddr = '0;
        fault = FAULT_NONE;

        case (opc)
            OPC_LOAD: begin
                maddr = ea;
                if (!(f3 inside {F3_LB, F3_LH, F3_LW, F3_LBU, F3_LHU})) begin
                    fault = FAULT_UNSUP;
                end else if (misal) begin
                    fault = FAULT_MISALIGN;
                end else begin
                    ld = 1'b1;
                    wr = 1'b1;
                end
            end
            OPC_STORE: begin
                maddr = ea;
                if (!(f3 inside {F3_SB, F3_SH, F3_SW})) begin
                    fault = FAULT_UNSUP;
                end else if (misal) begin
                    fault = FAULT_MISALIGN;
                end else begin
                    mw = 1'b1;
                end
            end
            OPC_OPIMM: begin
                case (f3)
                    F3_ADD: begin
                        val = ea;
                        wr  = 1'b1;
                    end
                    F3_AND: begin
                        val = i_a & immi;
                        wr  = 1'b1;
                    end
                    F3_SLL: begin
                        if (f7 == F7_BASE) begin
                            val = i_a << shamt;
                            wr  = 1'b1;
                        end else begin
                            fault = FAULT_UNSUP;
                        end
                    end
                    F3_SR: begin
                        if (f7 == F7_BASE) begin
                            val = i_a >> shamt;
                            wr  = 1'b1;
                        end else if (f7 == F7_ALT) begin
                            val = sra_val;
                            wr  = 1'b1;
                        end else begin
                            fault = FAULT_UNSUP;
                        end
                    end
                    default: fault = FAULT_UNSUP;
                endcase
            end
            OPC_OP: begin
                if (f3 != F3_ADD) begin
                    fault = FAULT_UNSUP;
                end else begin
                    case (f7)
                        F7_BASE: begin
                            val = i_a + i_b;
                            wr  = 1'b1;
                        end
                        F7_MUL: begin
                            val = mul_lo;
                            wr  = 1'b1;
                        end
                        F7_ALT: begin
                            val = i_a - i_b;
                            wr  = 1'b1;
                        end
                        default: fault = FAULT_UNSUP;
                    endcase
                end
            end
            OPC_LUI: begin
                val = {i_ins[31:12], 12'h000};
                wr  = 1'b1;
            end
            OPC_JAL: begin
                val = pc4;
                wr  = 1'b1;
                npc = pc_tgt;
            end
            OPC_JALR: begin
                if (f3 != F3_JALR) begin
                    fault = FAULT_UNSUP;
                end else begin
                    val = pc4;
                    wr  = 1'b1;
                    npc = {ea[31:1], 1'b0};
                end
            end
            OPC_BRANCH: begin
                case (f3)
                    F3_BEQ:  take = eq;
                    F3_BNE:  take = !eq;
                    F3_BLT:  take = lt_s;
                    F3_BGE:  take = !lt_s;
                    F3_BLTU: take = lt_u;
                    F3_BGEU: take = !lt_u;
                    default: fault = FAULT_UNSUP;
                endcase
                if (take) begin
                    npc = pc_tgt;
                end
            end
            default: fault = FAULT_UNSUP;
        endcase

        // Any fault: no side effects, fall through
        if (fault != FAULT_NONE) begin
            wr  = 1'b0;
            mw  = 1'b0;
            ld  = 1'b0;
            npc = pc4;
        end
        if (fault == FAULT_UNSUP) begin
            maddr = '0;
        end
        // x0 discards writes
        if (rd == 5'd0) begin
            wr = 1'b0;
        end
        if (!wr) begin
            val = '0;
        end
    end

    assign o_res.npc   = npc;
    assign o_res.wr    = wr;
    assign o_res.rd    = wr ? rd : 5'd0;
    assign o_res.val   = val;
    assign o_res.ld    = ld;
    assign o_res.f3    = f3;
    assign o_res.mw    = mw;
    assign o_res.maddr = maddr;
    assign o_res.fault = fault;

endmodule

/* src/rvxu_dmem.sv */
// Byte-addressed data memory, 32-bit rows with byte enables.
// Cleared row by row after reset; o_busy is high during the sweep.
module rvxu_dmem
    import rvxu_pkg::*;
#(
    parameter int DATA_MEM_BYTES = DMEM_BYTES_DEFAULT  // power of two, at least 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_mem_req    i_req,
    output logic [31:0] o_rdata,
    output logic        o_busy
);

    localparam int ROWS   = DATA_MEM_BYTES / 4;
    localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam logic [ROW_AW-1:0] LAST_ROW = ROW_AW'(ROWS - 1);
    localparam logic [29:0]       ROW_MASK = 30'(ROWS - 1);

    logic [31:0]       r_mem [0:ROWS-1];
    logic [31:0]       r_rdata;
    logic              r_clr_busy;
    logic [ROW_AW-1:0] r_clr_row;

    logic [ROW_AW-1:0] row;
    logic [3:0]        be;
    logic [31:0]       wdata_sh;

    // Address wraps modulo the memory size
    assign row = ROW_AW'(i_req.addr[31:2] & ROW_MASK);

    // Lane enables and data alignment; accesses are already aligned
    always_comb begin
        case (i_req.size)
            SIZE_BYTE: be = 4'b0001 << i_req.addr[1:0];
            SIZE_HALF: be = 4'b0011 << {i_req.addr[1], 1'b0};
            default:   be = 4'b1111;
        endcase
    end

    assign wdata_sh = i_req.wdata << {i_req.addr[1:0], 3'b000};

    // Clearing sweep
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_row  <= '0;
        end else if (r_clr_busy) begin
            if (r_clr_row == LAST_ROW) begin
                r_clr_busy <= 1'b0;
            end else begin
                r_clr_row <= r_clr_row + ROW_AW'(1);
            end
        end
    end

    // Storage: one write, one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            r_mem[r_clr_row] <= '0;
        end else if (i_req.wr_en) begin
            for (int b = 0; b < 4; b++) begin
                if (be[b]) begin
                    r_mem[row][8*b +: 8] <= wdata_sh[8*b +: 8];
                end
            end
        end
        if (i_req.rd_en) begin
            r_rdata <= r_mem[row];
        end
    end

    assign o_rdata = r_rdata;
    assign o_busy  = r_clr_busy;

endmodule
